// ===== rtl/spqr_pkg.sv =====
package spqr_pkg;

    localparam int CAPACITY    = 16;
    localparam int OCC_W       = $clog2(CAPACITY + 1);
    localparam int FUNC_W      = 2;
    localparam int KEY_W       = 16;
    localparam int LVL_W       = 2;
    localparam int ST_W        = 3;
    localparam int IN_FIELD_W  = FUNC_W + KEY_W + LVL_W;
    localparam int OUT_FIELD_W = ST_W + KEY_W + LVL_W;
    localparam int IN_TDATA_W  = ((IN_FIELD_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

    localparam logic [LVL_W-1:0] LVL_NONE = '0;

    typedef enum logic [FUNC_W-1:0] {
        FN_ENQ  = 2'd0,
        FN_DEQ  = 2'd1,
        FN_REM  = 2'd2,
        FN_RSVD = 2'd3
    } t_func;

    typedef enum logic [ST_W-1:0] {
        ST_ENQ      = 3'd0,
        ST_DEQ      = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_REMOVED  = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_FULL     = 3'd5,
        ST_BADLEVEL = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic capture;   // latch the incoming item
        logic exec;      // run the latched operation on the slot row
    } t_cmd;

endpackage

// ===== rtl/stable_priority_queue_with_remove_unit.sv =====
// Stable priority queue with removal by key.
//
// Input stream (i_s_*): one item per operation. tdata carries func
// (0 enqueue, 1 dequeue head, 2 remove by key), user_key and prio_level
// (1 normal, 2 vip, 3 svip). Output stream (o_m_*): exactly one item per
// input item, carrying status, out_key and out_level.
//
// Entries sit in a row of 16 slots, highest level first and in arrival
// order within a level. Each slot compares its own level and key with the
// latched item. All slots update at once: from the insert point right on
// insert, the whole row left on dequeue, from the match left on remove.
//
// Sequence: accept the item (S_IDLE), run the slot row (S_EXEC), then
// present the result (S_OUT) until it is taken; the sequencer keeps only
// one item in flight.
// o_s_tready is low from acceptance until the result is taken, so a
// stalled receiver holds the result stable and blocks new items.
//
// Reset (synchronous, active low) empties the queue and drops any result.
module stable_priority_queue_with_remove_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // [1:0] func, [17:2] user_key, [19:18] prio_level, [23:20] zero
    input  logic [spqr_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // [2:0] status, [18:3] out_key, [20:19] out_level, [23:21] zero
    output logic [spqr_pkg::OUT_TDATA_W-1:0]    o_m_tdata
);
    import spqr_pkg::*;

    t_cmd             cmd;
    logic [ST_W-1:0]  status;
    logic [KEY_W-1:0] out_key;
    logic [LVL_W-1:0] out_level;

    // sequence one item at a time: accept, execute, deliver
    spqr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_cmd      (cmd)
    );

    // slot row plus latched item and result registers
    spqr_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_func       (i_s_tdata[FUNC_W-1:0]),
        .i_user_key   (i_s_tdata[FUNC_W +: KEY_W]),
        .i_prio_level (i_s_tdata[FUNC_W+KEY_W +: LVL_W]),
        .o_status     (status),
        .o_out_key    (out_key),
        .o_out_level  (out_level)
    );

    // pack the result, zero-fill up to whole bytes
    assign o_m_tdata = {{(OUT_TDATA_W - OUT_FIELD_W){1'b0}}, out_level, out_key, status};

endmodule

// ===== rtl/spqr_ctrl.sv =====
module spqr_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    output spqr_pkg::t_cmd o_cmd
);
    import spqr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_s_tready  = 1'b0;
        o_m_tvalid  = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_m_tvalid = 1'b1;
                if (i_m_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    a_ready_result_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_s_tready && o_m_tvalid))
        else $error("input ready while a result is pending");

    a_exec_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> !o_cmd.exec && o_m_tvalid)
        else $error("exec not followed by result");

    a_capture_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> o_cmd.exec)
        else $error("captured item not executed");

endmodule

// ===== rtl/spqr_dp.sv =====
module spqr_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  spqr_pkg::t_cmd                  i_cmd,
    input  logic [spqr_pkg::FUNC_W-1:0]     i_func,
    input  logic [spqr_pkg::KEY_W-1:0]      i_user_key,
    input  logic [spqr_pkg::LVL_W-1:0]      i_prio_level,
    output logic [spqr_pkg::ST_W-1:0]       o_status,
    output logic [spqr_pkg::KEY_W-1:0]      o_out_key,
    output logic [spqr_pkg::LVL_W-1:0]      o_out_level
);
    import spqr_pkg::*;

    t_func            r_func;
    logic [KEY_W-1:0] r_key;
    logic [LVL_W-1:0] r_lvl;

    logic [KEY_W-1:0] r_slot_key [CAPACITY];
    logic [LVL_W-1:0] r_slot_lvl [CAPACITY];
    logic [KEY_W-1:0] n_slot_key [CAPACITY];
    logic [LVL_W-1:0] n_slot_lvl [CAPACITY];
    logic [OCC_W-1:0] r_occ;
    logic [OCC_W-1:0] n_occ;

    t_status          r_status;
    t_status          n_status;
    logic [KEY_W-1:0] r_okey;
    logic [KEY_W-1:0] n_okey;
    logic [LVL_W-1:0] r_olvl;
    logic [LVL_W-1:0] n_olvl;

    logic [CAPACITY-1:0] slot_valid;
    logic [CAPACITY-1:0] slot_ahead;   // stays ahead of a new entry
    logic [CAPACITY-1:0] slot_match;
    logic [CAPACITY-1:0] slot_past;    // at or after the first match
    logic                full;
    logic                empty;
    logic                found;

    // per-slot compare row
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            slot_valid[i] = OCC_W'(i) < r_occ;
            slot_ahead[i] = slot_valid[i] && (r_slot_lvl[i] >= r_lvl);
            slot_match[i] = slot_valid[i] && (r_slot_key[i] == r_key);
        end
        slot_past[0] = slot_match[0];
        for (int i = 1; i < CAPACITY; i++) begin
            slot_past[i] = slot_past[i-1] | slot_match[i];
        end
        full  = r_occ == OCC_W'(CAPACITY);
        empty = r_occ == '0;
        found = |slot_match;
    end

    always_comb begin
        n_slot_key = r_slot_key;
        n_slot_lvl = r_slot_lvl;
        n_occ      = r_occ;
        n_status   = ST_BADLEVEL;
        n_okey     = '0;
        n_olvl     = '0;
        case (r_func)
            FN_ENQ: begin
                if (r_lvl == LVL_NONE) begin
                    n_status = ST_BADLEVEL;
                end else if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_status = ST_ENQ;
                    n_occ    = r_occ + OCC_W'(1);
                    if (!slot_ahead[0]) begin
                        n_slot_key[0] = r_key;
                        n_slot_lvl[0] = r_lvl;
                    end
                    for (int i = 1; i < CAPACITY; i++) begin
                        if (!slot_ahead[i]) begin
                            if (slot_ahead[i-1]) begin
                                n_slot_key[i] = r_key;
                                n_slot_lvl[i] = r_lvl;
                            end else begin
                                n_slot_key[i] = r_slot_key[i-1];
                                n_slot_lvl[i] = r_slot_lvl[i-1];
                            end
                        end
                    end
                end
            end
            FN_DEQ: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_status = ST_DEQ;
                    n_okey   = r_slot_key[0];
                    n_olvl   = r_slot_lvl[0];
                    n_occ    = r_occ - OCC_W'(1);
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        n_slot_key[i] = r_slot_key[i+1];
                        n_slot_lvl[i] = r_slot_lvl[i+1];
                    end
                end
            end
            FN_REM: begin
                if (!found) begin
                    n_status = ST_NOTFOUND;
                end else begin
                    n_status = ST_REMOVED;
                    n_okey   = r_key;
                    n_occ    = r_occ - OCC_W'(1);
                    for (int i = 0; i < CAPACITY - 1; i++) begin
                        if (slot_past[i]) begin
                            n_slot_key[i] = r_slot_key[i+1];
                            n_slot_lvl[i] = r_slot_lvl[i+1];
                        end
                    end
                end
            end
            default: begin
                n_status = ST_BADLEVEL;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.exec) begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= t_func'(i_func);
            r_key  <= i_user_key;
            r_lvl  <= i_prio_level;
        end
        if (i_cmd.exec) begin
            r_slot_key <= n_slot_key;
            r_slot_lvl <= n_slot_lvl;
            r_status   <= n_status;
            r_okey     <= n_okey;
            r_olvl     <= n_olvl;
        end
    end

    assign o_status    = r_status;
    assign o_out_key   = r_okey;
    assign o_out_level = r_olvl;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= OCC_W'(CAPACITY))
        else $error("occupancy beyond capacity");

    a_enq_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (r_status != ST_ENQ) || (r_occ == $past(r_occ) + OCC_W'(1)))
        else $error("enqueue did not add an entry");

    a_drop_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> !(r_status == ST_DEQ || r_status == ST_REMOVED)
            || (r_occ == $past(r_occ) - OCC_W'(1)))
        else $error("dequeue or remove did not drop an entry");

    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> !(r_status == ST_FULL || r_status == ST_BADLEVEL
            || r_status == ST_EMPTY || r_status == ST_NOTFOUND) || $stable(r_occ))
        else $error("rejected item changed occupancy");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps

// Checks the stable priority queue: enqueue by level, dequeue of the head and
// removal by key. Every accepted item is run through a queue model kept here,
// and the answer it gives is held until the block returns its result item,
// which is compared field by field.
module tb;
    import spqr_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLDOFF_CYCLES = 300;

    typedef struct packed {
        t_status          status;
        logic [KEY_W-1:0] key;
        logic [LVL_W-1:0] lvl;
    } t_queue_reply;

    logic                   i_clk;
    logic                   i_rst_n    = 1'b0;
    logic                   i_s_tvalid = 1'b0;
    logic                   o_s_tready;
    // [1:0] func, [17:2] user_key, [19:18] prio_level, [23:20] zero
    logic [IN_TDATA_W-1:0]  i_s_tdata  = '0;
    logic                   o_m_tvalid;
    logic                   i_m_tready = 1'b0;
    // [2:0] status, [18:3] out_key, [20:19] out_level, [23:21] zero
    logic [OUT_TDATA_W-1:0] o_m_tdata;

    // Queue contents as the block should hold them, head at index 0.
    logic [KEY_W-1:0] line_key [CAPACITY];
    logic [LVL_W-1:0] line_lvl [CAPACITY];
    int unsigned      line_len = 0;

    t_queue_reply expected_replies[$];
    int           error_count   = 0;
    int           idle_cycles   = 0;

    // Sender and receiver pacing, steered by the test tasks.
    bit sender_gaps       = 1'b1;
    int sender_burst_left = 0;
    bit sink_free         = 1'b0;
    int sink_hold_cycles  = 0;
    int sink_mode         = 0;
    int sink_run_left     = 0;

    stable_priority_queue_with_remove_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Apply one operation to the queue model and return the answer it gives.
    function automatic t_queue_reply serve_operation(t_func fn, logic [KEY_W-1:0] key,
                                                     logic [LVL_W-1:0] lvl);
        t_queue_reply reply;
        int unsigned  pos;
        reply.status = ST_BADLEVEL;
        reply.key    = '0;
        reply.lvl    = LVL_NONE;
        case (fn)
            FN_ENQ: begin
                if (lvl == LVL_NONE) begin
                    reply.status = ST_BADLEVEL;
                end else if (line_len >= CAPACITY) begin
                    reply.status = ST_FULL;
                end else begin
                    // Go behind every entry of equal or higher level.
                    pos = 0;
                    while (pos < line_len && line_lvl[pos] >= lvl) pos++;
                    for (int i = line_len; i > pos; i--) begin
                        line_key[i] = line_key[i-1];
                        line_lvl[i] = line_lvl[i-1];
                    end
                    line_key[pos] = key;
                    line_lvl[pos] = lvl;
                    line_len++;
                    reply.status = ST_ENQ;
                end
            end
            FN_DEQ: begin
                if (line_len == 0) begin
                    reply.status = ST_EMPTY;
                end else begin
                    reply.status = ST_DEQ;
                    reply.key    = line_key[0];
                    reply.lvl    = line_lvl[0];
                    for (int i = 0; i + 1 < line_len; i++) begin
                        line_key[i] = line_key[i+1];
                        line_lvl[i] = line_lvl[i+1];
                    end
                    line_len--;
                end
            end
            FN_REM: begin
                // First match from the head wins; the level is not reported.
                pos = 0;
                while (pos < line_len && line_key[pos] != key) pos++;
                if (pos < line_len) begin
                    reply.status = ST_REMOVED;
                    reply.key    = line_key[pos];
                    for (int i = pos; i + 1 < line_len; i++) begin
                        line_key[i] = line_key[i+1];
                        line_lvl[i] = line_lvl[i+1];
                    end
                    line_len--;
                end else begin
                    reply.status = ST_NOTFOUND;
                end
            end
            default: reply.status = ST_BADLEVEL;
        endcase
        return reply;
    endfunction

    // Offer one item, hold it until taken, then record the answer it must get.
    task automatic send_op(t_func fn, logic [KEY_W-1:0] key, logic [LVL_W-1:0] lvl);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_TDATA_W - IN_FIELD_W){1'b0}}, lvl, key, fn};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_replies.push_back(serve_operation(fn, key, lvl));
        if (sender_gaps) begin
            if (sender_burst_left == 0) begin
                sender_burst_left = $urandom_range(1, 24);
                i_s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
            end else begin
                sender_burst_left--;
            end
        end
    endtask

    // Drop valid and wait until every outstanding result has come back.
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (expected_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Random operations: a few reserved and bad-level items, the rest split
    // by the given shares. Removes mostly target a key that is queued.
    task automatic send_mixed(int n, int enq_pct, int deq_pct, int key_span);
        int               r;
        t_func            fn;
        logic [KEY_W-1:0] key;
        logic [LVL_W-1:0] lvl;
        for (int k = 0; k < n; k++) begin
            r   = $urandom_range(0, 99);
            lvl = LVL_W'($urandom_range(1, 3));
            key = KEY_W'($urandom_range(0, key_span));
            if (r < 3) begin
                fn  = FN_RSVD;
                lvl = LVL_W'($urandom_range(0, 3));
                key = KEY_W'($urandom);
            end else if (r < 7) begin
                fn  = FN_ENQ;
                lvl = LVL_NONE;
            end else if (r < 7 + enq_pct) begin
                fn = FN_ENQ;
            end else if (r < 7 + enq_pct + deq_pct) begin
                fn = FN_DEQ;
            end else begin
                fn = FN_REM;
                if (line_len != 0 && $urandom_range(0, 3) != 0)
                    key = line_key[$urandom_range(0, line_len - 1)];
            end
            send_op(fn, key, lvl);
        end
    endtask

    task automatic run_directed_cases();
        send_op(FN_DEQ,  16'h0000, LVL_NONE);     // dequeue on empty
        send_op(FN_REM,  16'h1234, 2'd1);         // remove on empty
        send_op(FN_RSVD, 16'hFFFF, 2'd3);         // unused operation
        send_op(FN_ENQ,  16'hABCD, LVL_NONE);     // bad level
        send_op(FN_ENQ,  16'h0000, 2'd1);
        send_op(FN_ENQ,  16'hFFFF, 2'd3);
        send_op(FN_ENQ,  16'h5555, 2'd2);
        send_op(FN_ENQ,  16'hAAAA, 2'd3);         // queues behind the first svip
        send_op(FN_DEQ,  16'hFFFF, 2'd3);
        send_op(FN_REM,  16'h5555, 2'd2);         // found in the middle
        send_op(FN_REM,  16'h5555, 2'd2);         // now gone
        // Fill to capacity with mixed levels.
        for (int i = 0; i < CAPACITY - 2; i++)
            send_op(FN_ENQ, KEY_W'(16'h1111 * (i + 1)), LVL_W'(i % 3 + 1));
        send_op(FN_ENQ, 16'h7777, 2'd2);          // full
        send_op(FN_ENQ, 16'h8888, LVL_NONE);      // bad level wins over full
        wait_drained();
    endtask

    task automatic run_mixed_traffic();
        send_mixed(400, 34, 27, 65535);
        wait_drained();
    endtask

    // Swing between filling and draining so both full and empty are hit often.
    task automatic run_fill_drain_cycles();
        for (int p = 0; p < 6; p++) begin
            if (p % 2 == 0) send_mixed(50, 70, 10, 255);
            else            send_mixed(50, 10, 45, 255);
        end
        wait_drained();
    endtask

    // Stall the receiver for a long stretch while items keep coming.
    task automatic run_sink_holdoff();
        sender_gaps      = 1'b0;
        sink_hold_cycles = HOLDOFF_CYCLES;
        send_mixed(40, 45, 25, 63);
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    task automatic run_back_to_back();
        sender_gaps = 1'b0;
        sink_free   = 1'b1;
        send_mixed(200, 40, 25, 1023);
        sink_free   = 1'b0;
        sender_gaps = 1'b1;
        wait_drained();
    endtask

    // A tiny key pool makes repeated keys, so removal must take the first one.
    task automatic run_duplicate_keys();
        send_mixed(250, 45, 15, 3);
        wait_drained();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed_cases();
        run_mixed_traffic();
        run_fill_drain_cycles();
        run_sink_holdoff();
        run_back_to_back();
        run_duplicate_keys();

        repeat (8) @(posedge i_clk);
        if (error_count == 0 && expected_replies.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Receiver: honor a requested hold-off first, then a forced always-ready, else
    // follow random stretches of always-ready, coin-flip and mostly-stalled behavior.
    always @(posedge i_clk) begin
        if (sink_hold_cycles > 0) begin
            i_m_tready <= 1'b0;
            sink_hold_cycles = sink_hold_cycles - 1;
        end else if (sink_free) begin
            i_m_tready <= 1'b1;
        end else begin
            if (sink_run_left == 0) begin
                sink_mode     = $urandom_range(0, 2);
                sink_run_left = $urandom_range(8, 60);
            end else begin
                sink_run_left = sink_run_left - 1;
            end
            case (sink_mode)
                0:       i_m_tready <= 1'b1;
                1:       i_m_tready <= $urandom_range(0, 1);
                default: i_m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each taken result with the oldest outstanding answer.
    always @(posedge i_clk) begin
        t_queue_reply want;
        t_queue_reply got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.status = t_status'(o_m_tdata[ST_W-1:0]);
            got.key    = o_m_tdata[ST_W +: KEY_W];
            got.lvl    = o_m_tdata[ST_W + KEY_W +: LVL_W];
            if (expected_replies.size() == 0) begin
                $error("result with nothing outstanding: tdata %h", o_m_tdata);
                error_count++;
            end else begin
                want = expected_replies.pop_front();
                if (got.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    error_count++;
                end
                if (got.key !== want.key) begin
                    $error("out_key: expected %h, got %h", want.key, got.key);
                    error_count++;
                end
                if (got.lvl !== want.lvl) begin
                    $error("out_level: expected %0d, got %0d", want.lvl, got.lvl);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: end the run if no item moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule
